// File: src/brq_pkg.sv
`default_nettype none

package brq_pkg;

  // Field widths of the two channels.
  localparam int CMD_W   = 2;
  localparam int LEN_W   = 13;
  localparam int BYTE_W  = 8;
  localparam int ST_W    = 2;
  localparam int FREE_W  = 13;
  localparam int MS_W    = 8;

  // Default sizing.
  localparam int DEPTH_DEF        = 4096;
  localparam int BYTES_PER_MS_DEF = 32;
  localparam int MAX_READ_DEF     = 64;

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_ARG = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } st_t;

  // Read sequencer states.
  typedef enum logic {
    RS_IDLE = 1'b0,
    RS_RUN  = 1'b1
  } run_state_t;

  // Result descriptor handed from the controller to the output buffer.
  typedef struct packed {
    st_t  status;
    logic last;
    logic from_mem;
  } res_t;

endpackage

`default_nettype wire

// File: src/brq_store.sv
`default_nettype none

module brq_store #(
  parameter int DEPTH = brq_pkg::DEPTH_DEF,
  parameter int PTR_W = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [PTR_W-1:0]          waddr,
  input  wire logic [brq_pkg::BYTE_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [PTR_W-1:0]          raddr,
  output logic      [brq_pkg::BYTE_W-1:0] rdata
);
  import brq_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: src/brq_ctrl.sv
`default_nettype none

module brq_ctrl #(
  parameter int DEPTH    = brq_pkg::DEPTH_DEF,
  parameter int MAX_READ = brq_pkg::MAX_READ_DEF,
  parameter int PTR_W    = $clog2(DEPTH),
  parameter int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [brq_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic                        in_burst_start,
  input  wire logic [brq_pkg::LEN_W-1:0]   in_transfer_length,
  input  wire logic [brq_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic                        room,
  output logic                             mem_we,
  output logic      [PTR_W-1:0]            mem_waddr,
  output logic      [brq_pkg::BYTE_W-1:0]  mem_wdata,
  output logic                             mem_re,
  output logic      [PTR_W-1:0]            mem_raddr,
  output logic                             s1_valid,
  output brq_pkg::res_t                    s1_res,
  output logic      [CNT_W-1:0]            held
);
  import brq_pkg::*;

  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int RUN_W = $clog2(MAX_READ + 1);

  run_state_t       state_r, state_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [LEN_W-1:0] burst_rem_r, burst_rem_nxt;
  logic             burst_ref_r, burst_ref_nxt;
  logic [RUN_W-1:0] run_left_r, run_left_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  res_t             s1_res_r, s1_res_nxt;

  logic             acc;
  logic             run_go;
  logic             rd_len_bad;
  logic             rd_len_short;
  logic             read_go;
  logic [CMP_W-1:0] len_x;
  logic [CMP_W-1:0] held_x;
  logic [CMP_W-1:0] free_x;
  logic [PTR_W-1:0] wr_ptr_inc;
  logic [PTR_W-1:0] rd_ptr_inc;

  // One item at a time; a read run holds off the next item.
  assign in_stall = (state_r != RS_IDLE) || !room;
  assign acc      = in_valid && !in_stall;
  assign run_go   = (state_r == RS_RUN) && room;

  assign len_x  = CMP_W'(in_transfer_length);
  assign held_x = CMP_W'(held_r);
  assign free_x = CMP_W'(DEPTH) - held_x;

  assign rd_len_bad   = (in_transfer_length == '0) ||
                        (in_transfer_length > LEN_W'(MAX_READ));
  assign rd_len_short = len_x > held_x;
  assign read_go      = acc && (cmd_t'(in_cmd) == CMD_READ) && !rd_len_bad && !rd_len_short;

  // Pointer wrap for any depth.
  assign wr_ptr_inc = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  // Queue state update and store accesses.
  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    held_nxt      = held_r;
    burst_rem_nxt = burst_rem_r;
    burst_ref_nxt = burst_ref_r;
    run_left_nxt  = run_left_r;
    s1_valid_nxt  = 1'b0;
    s1_res_nxt    = '{status: ST_OK, last: 1'b1, from_mem: 1'b0};
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    if (acc) begin
      s1_valid_nxt = 1'b1;
      case (cmd_t'(in_cmd))
        CMD_WRITE: begin
          if (in_burst_start) begin
            burst_rem_nxt = '0;
            burst_ref_nxt = 1'b0;
            if (in_transfer_length == '0) begin
              s1_res_nxt.status = ST_BAD_ARG;
            end else if (len_x > free_x) begin
              burst_rem_nxt     = in_transfer_length - 1'b1;
              burst_ref_nxt     = 1'b1;
              s1_res_nxt.status = ST_FULL;
            end else begin
              burst_rem_nxt = in_transfer_length - 1'b1;
              mem_we        = 1'b1;
              wr_ptr_nxt    = wr_ptr_inc;
              held_nxt      = held_r + 1'b1;
            end
          end else if (burst_rem_r == '0) begin
            s1_res_nxt.status = ST_BAD_ARG;
          end else begin
            burst_rem_nxt = burst_rem_r - 1'b1;
            if (burst_ref_r || (held_x >= CMP_W'(DEPTH))) begin
              s1_res_nxt.status = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              wr_ptr_nxt = wr_ptr_inc;
              held_nxt   = held_r + 1'b1;
            end
          end
        end
        CMD_READ: begin
          if (rd_len_bad) begin
            s1_res_nxt.status = ST_BAD_ARG;
          end else if (rd_len_short) begin
            s1_res_nxt.status = ST_EMPTY;
          end else begin
            mem_re              = 1'b1;
            rd_ptr_nxt          = rd_ptr_inc;
            held_nxt            = held_r - CNT_W'(in_transfer_length);
            run_left_nxt        = RUN_W'(in_transfer_length - 1'b1);
            s1_res_nxt.last     = (in_transfer_length == LEN_W'(1));
            s1_res_nxt.from_mem = 1'b1;
          end
        end
        CMD_CLEAR: begin
          rd_ptr_nxt    = '0;
          wr_ptr_nxt    = '0;
          held_nxt      = '0;
          burst_rem_nxt = '0;
          burst_ref_nxt = 1'b0;
        end
        default: begin
          s1_res_nxt.status = ST_BAD_ARG;
        end
      endcase
    end else if (run_go) begin
      // Remaining bytes of a read run, one store read per cycle while the output buffer has room.
      s1_valid_nxt        = 1'b1;
      mem_re              = 1'b1;
      rd_ptr_nxt          = rd_ptr_inc;
      run_left_nxt        = run_left_r - 1'b1;
      s1_res_nxt.last     = (run_left_r == RUN_W'(1));
      s1_res_nxt.from_mem = 1'b1;
    end
  end

  // Read sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      RS_IDLE: begin
        if (read_go && (in_transfer_length != LEN_W'(1))) begin
          state_nxt = RS_RUN;
        end
      end
      RS_RUN: begin
        if (run_go && (run_left_r == RUN_W'(1))) begin
          state_nxt = RS_IDLE;
        end
      end
      default: begin
        state_nxt = RS_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= RS_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      held_r      <= '0;
      burst_rem_r <= '0;
      burst_ref_r <= 1'b0;
      run_left_r  <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      held_r      <= held_nxt;
      burst_rem_r <= burst_rem_nxt;
      burst_ref_r <= burst_ref_nxt;
      run_left_r  <= run_left_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  // Result descriptor travels alongside the store read.
  always_ff @(posedge clk) begin
    s1_res_r <= s1_res_nxt;
  end

  assign mem_waddr = wr_ptr_r;
  assign mem_wdata = in_data_byte;
  assign mem_raddr = rd_ptr_r;
  assign s1_valid  = s1_valid_r;
  assign s1_res    = s1_res_r;
  assign held      = held_r;

endmodule

`default_nettype wire

// File: src/brq_outbuf.sv
`default_nettype none

module brq_outbuf #(
  parameter int DEPTH        = brq_pkg::DEPTH_DEF,
  parameter int BYTES_PER_MS = brq_pkg::BYTES_PER_MS_DEF,
  parameter int CNT_W        = $clog2(DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        s1_valid,
  input  brq_pkg::res_t                    s1_res,
  input  wire logic [brq_pkg::BYTE_W-1:0]  rdata,
  input  wire logic [CNT_W-1:0]            held,
  output logic                             room,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [brq_pkg::ST_W-1:0]    out_status,
  output logic      [brq_pkg::BYTE_W-1:0]  out_read_byte,
  output logic                             out_last,
  output logic      [brq_pkg::FREE_W-1:0]  out_free_bytes,
  output logic      [brq_pkg::MS_W-1:0]    out_queued_ms
);
  import brq_pkg::*;

  // held / BYTES_PER_MS as a multiply by a rounded-up reciprocal, exact for held < 2**CNT_W.
  localparam int    SH     = CNT_W + $clog2(BYTES_PER_MS);
  localparam longint MUL_L = ((longint'(1) <<< SH) + longint'(BYTES_PER_MS) - 1)
                             / longint'(BYTES_PER_MS);
  localparam int    MUL_W  = CNT_W + 2;
  localparam int    PW     = ((SH + MS_W) > (CNT_W + MUL_W)) ? (SH + MS_W) : (CNT_W + MUL_W);
  localparam logic [PW-1:0] MUL = PW'(MUL_L);
  localparam int    FW     = (CNT_W > FREE_W) ? CNT_W : FREE_W;

  logic [ST_W-1:0]   st_q   [2];
  logic [BYTE_W-1:0] byte_q [2];
  logic              last_q [2];
  logic [FREE_W-1:0] free_q [2];
  logic [MS_W-1:0]   ms_q   [2];

  logic       wr_idx_r, wr_idx_nxt;
  logic       rd_idx_r, rd_idx_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [PW-1:0] prod;
  logic [FW-1:0] free_w;

  assign pop  = out_valid && !out_stall;
  // Space for one more result counting the one already in flight.
  assign room = ({1'b0, cnt_r} + {2'b00, s1_valid}) < (3'd2 + {2'b00, pop});

  assign prod   = PW'(held) * MUL;
  assign free_w = FW'(DEPTH) - FW'(held);

  // Occupancy and index update.
  always_comb begin
    wr_idx_nxt = s1_valid ? ~wr_idx_r : wr_idx_r;
    rd_idx_nxt = pop ? ~rd_idx_r : rd_idx_r;
    cnt_nxt    = cnt_r + {1'b0, s1_valid} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= 1'b0;
      rd_idx_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result entry written when the store data arrives.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      st_q[wr_idx_r]   <= s1_res.status;
      byte_q[wr_idx_r] <= s1_res.from_mem ? rdata : '0;
      last_q[wr_idx_r] <= s1_res.last;
      free_q[wr_idx_r] <= free_w[FREE_W-1:0];
      ms_q[wr_idx_r]   <= prod[SH +: MS_W];
    end
  end

  assign out_valid      = (cnt_r != '0);
  assign out_status     = st_q[rd_idx_r];
  assign out_read_byte  = byte_q[rd_idx_r];
  assign out_last       = last_q[rd_idx_r];
  assign out_free_bytes = free_q[rd_idx_r];
  assign out_queued_ms  = ms_q[rd_idx_r];

endmodule

`default_nettype wire

// File: src/byte_ring_queue_all_or_nothing_core.sv
// Channel | Dir | Fields                                        | Handshake
// input   | in  | cmd, burst_start, transfer_length, data_byte  | in_valid / in_stall
// result  | out | status, read_byte, last, free_bytes, queued_ms | out_valid / out_stall
//
// Writes, clears and refused commands each give one result. A read of N bytes gives
// N results, one byte per cycle while the output buffer has room, through the single
// read port of the sample store; results pass the store read register, then the buffer.
// Synchronous active-low reset clears pointers, count and burst state; no clearing pass.
// A two-entry output buffer holds the results in flight; issue pauses in any cycle where
// two results are buffered or in flight and the result side stalls.
`default_nettype none

module byte_ring_queue_all_or_nothing_core #(
  parameter int DEPTH        = brq_pkg::DEPTH_DEF,
  parameter int BYTES_PER_MS = brq_pkg::BYTES_PER_MS_DEF,
  parameter int MAX_READ     = brq_pkg::MAX_READ_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [brq_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic                        in_burst_start,
  input  wire logic [brq_pkg::LEN_W-1:0]   in_transfer_length,
  input  wire logic [brq_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [brq_pkg::ST_W-1:0]    out_status,
  output logic      [brq_pkg::BYTE_W-1:0]  out_read_byte,
  output logic                             out_last,
  output logic      [brq_pkg::FREE_W-1:0]  out_free_bytes,
  output logic      [brq_pkg::MS_W-1:0]    out_queued_ms
);
  import brq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic              room;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  logic              s1_valid;
  res_t              s1_res;
  logic [CNT_W-1:0]  held;

  // Command decode, pointers and burst bookkeeping.
  brq_ctrl #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ),
    .PTR_W    (PTR_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_burst_start     (in_burst_start),
    .in_transfer_length (in_transfer_length),
    .in_data_byte       (in_data_byte),
    .room               (room),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_re             (mem_re),
    .mem_raddr          (mem_raddr),
    .s1_valid           (s1_valid),
    .s1_res             (s1_res),
    .held               (held)
  );

  // Sample store.
  brq_store #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result assembly and output buffering.
  brq_outbuf #(
    .DEPTH        (DEPTH),
    .BYTES_PER_MS (BYTES_PER_MS),
    .CNT_W        (CNT_W)
  ) u_outbuf (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_valid       (s1_valid),
    .s1_res         (s1_res),
    .rdata          (mem_rdata),
    .held           (held),
    .room           (room),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_byte  (out_read_byte),
    .out_last       (out_last),
    .out_free_bytes (out_free_bytes),
    .out_queued_ms  (out_queued_ms)
  );

endmodule

`default_nettype wire

// File: src/brq_checker.sv
`default_nettype none

module brq_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [brq_pkg::ST_W-1:0]   out_status,
  input wire logic [brq_pkg::BYTE_W-1:0] out_read_byte,
  input wire logic                       out_last,
  input wire logic [brq_pkg::FREE_W-1:0] out_free_bytes,
  input wire logic [brq_pkg::MS_W-1:0]   out_queued_ms
);
  import brq_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_read_byte) && $stable(out_last) && $stable(out_free_bytes) &&
    $stable(out_queued_ms))
    else $error("result changed while stalled");

  // Any status other than ok is a single result and ends its item.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last)
    else $error("error status without last");

  // Only read bytes carry data.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_read_byte == '0))
    else $error("nonzero byte on status result");

  // Results of one read run all report the same level.
  a_run_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> !out_valid ||
    ((out_free_bytes == $past(out_free_bytes)) && (out_queued_ms == $past(out_queued_ms))))
    else $error("level changed within a read run");

endmodule

bind byte_ring_queue_all_or_nothing_core brq_checker u_brq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_read_byte  (out_read_byte),
  .out_last       (out_last),
  .out_free_bytes (out_free_bytes),
  .out_queued_ms  (out_queued_ms)
);

`default_nettype wire

// File: dv/tb_byte_ring_queue_all_or_nothing_core.sv
`default_nettype none

module tb_byte_ring_queue_all_or_nothing_core;
  timeunit 1ns;
  timeprecision 1ps;

  import brq_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int BYTES_PER_MS = BYTES_PER_MS_DEF;
  localparam int MAX_READ     = MAX_READ_DEF;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int IDLE_PCT     = 17;
  localparam int RANDOM_ITEMS = 170;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS   = 60;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One expected result on the output channel.
  typedef struct {
    logic [ST_W-1:0]   status;
    logic [BYTE_W-1:0] rd_byte;
    logic              last;
    logic [FREE_W-1:0] free;
    logic [MS_W-1:0]   ms;
  } queue_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd;
  logic                in_burst_start;
  logic [LEN_W-1:0]    in_transfer_length;
  logic [BYTE_W-1:0]   in_data_byte;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ST_W-1:0]     out_status;
  logic [BYTE_W-1:0]   out_read_byte;
  logic                out_last;
  logic [FREE_W-1:0]   out_free_bytes;
  logic [MS_W-1:0]     out_queued_ms;

  int idle_pct  = IDLE_PCT;
  int stall_pct = IDLE_PCT;
  int errors    = 0;
  int items_sent = 0;
  int results_seen = 0;

  queue_result_t pending_results[$];

  // Shadow copy of the queue contents, pointers and burst state.
  logic [BYTE_W-1:0] shadow_mem [DEPTH];
  int unsigned rd_pos;
  int unsigned wr_pos;
  int unsigned held;
  int unsigned burst_left;
  bit          burst_dropped;

  byte_ring_queue_all_or_nothing_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_burst_start     (in_burst_start),
    .in_transfer_length (in_transfer_length),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_read_byte      (out_read_byte),
    .out_last           (out_last),
    .out_free_bytes     (out_free_bytes),
    .out_queued_ms      (out_queued_ms)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Random back pressure on the result channel.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Queue one expected result, reporting the occupancy after the step.
  function automatic void log_result(logic [ST_W-1:0] st, logic [BYTE_W-1:0] b, logic lst);
    queue_result_t r;
    r.status  = st;
    r.rd_byte = b;
    r.last    = lst;
    r.free    = FREE_W'(DEPTH - held);
    r.ms      = MS_W'(held / BYTES_PER_MS);
    pending_results.push_back(r);
  endfunction

  function automatic void store_byte(logic [BYTE_W-1:0] b);
    shadow_mem[PTR_W'(wr_pos)] = b;
    wr_pos = (wr_pos + 1) % DEPTH;
    held++;
  endfunction

  // Advance the shadow queue by one accepted item and record its results.
  function automatic void predict_queue_item(logic [CMD_W-1:0] cmd, logic start,
                                             logic [LEN_W-1:0] len, logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] taken[$];
    int unsigned n;
    logic [ST_W-1:0] st;
    n = len;
    taken = {};
    case (cmd)
      CMD_WRITE: begin
        if (start) begin
          // A new burst abandons any open one and is judged as a whole.
          burst_left = 0;
          burst_dropped = 0;
          if (n == 0) begin
            st = ST_BAD_ARG;
          end else if (n > DEPTH - held) begin
            burst_left = n - 1;
            burst_dropped = 1;
            st = ST_FULL;
          end else begin
            store_byte(data);
            burst_left = n - 1;
            st = ST_OK;
          end
        end else if (burst_left == 0) begin
          st = ST_BAD_ARG;
        end else begin
          burst_left--;
          if (burst_dropped || held >= DEPTH) begin
            st = ST_FULL;
          end else begin
            store_byte(data);
            st = ST_OK;
          end
        end
        log_result(st, '0, 1'b1);
      end
      CMD_READ: begin
        if (n == 0 || n > MAX_READ) begin
          log_result(ST_BAD_ARG, '0, 1'b1);
        end else if (n > held) begin
          log_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            taken.push_back(shadow_mem[PTR_W'(rd_pos)]);
            rd_pos = (rd_pos + 1) % DEPTH;
          end
          held -= n;
          for (int i = 0; i < n; i++) log_result(ST_OK, taken[i], i == n - 1);
        end
      end
      CMD_CLEAR: begin
        rd_pos = 0;
        wr_pos = 0;
        held = 0;
        burst_left = 0;
        burst_dropped = 0;
        log_result(ST_OK, '0, 1'b1);
      end
      default: begin
        log_result(ST_BAD_ARG, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (errors < MAX_PRINTS)
      $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  // Compare one accepted result with the oldest expectation.
  task automatic check_result();
    queue_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with none expected, status", out_status, 0);
    end else begin
      want = pending_results.pop_front();
      if (out_status !== want.status) report_mismatch("status", out_status, want.status);
      if (out_read_byte !== want.rd_byte) report_mismatch("read_byte", out_read_byte, want.rd_byte);
      if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      if (out_free_bytes !== want.free) report_mismatch("free_bytes", out_free_bytes, want.free);
      if (out_queued_ms !== want.ms) report_mismatch("queued_ms", out_queued_ms, want.ms);
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
  end

  // Offer one item, wait until it is taken, then predict its results.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic start, logic [LEN_W-1:0] len,
                           logic [BYTE_W-1:0] data);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_cmd             <= cmd;
    in_burst_start     <= start;
    in_transfer_length <= len;
    in_data_byte       <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_queue_item(cmd, start, len, data);
    items_sent++;
  endtask

  // A burst announcing total bytes, of which only count are sent.
  task automatic send_burst(int total, int count);
    for (int i = 0; i < count; i++) begin
      send_item(CMD_WRITE, i == 0,
                (i == 0) ? LEN_W'(total) : LEN_W'($urandom_range(8191)),
                BYTE_W'($urandom_range(255)));
    end
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write rules: zero length, stray bytes, abandoned and refused bursts.
  task automatic test_write_rules();
    send_item(CMD_WRITE, 1'b1, 0, 8'h11);
    send_item(CMD_WRITE, 1'b0, 0, 8'h22);
    send_item(CMD_WRITE, 1'b1, 1, 8'h00);
    send_item(CMD_WRITE, 1'b1, 3, 8'hFF);
    send_item(CMD_WRITE, 1'b0, 0, 8'h55);
    send_item(CMD_WRITE, 1'b0, 8191, 8'hAA);
    send_item(CMD_WRITE, 1'b0, 0, 8'h01);
    send_item(CMD_WRITE, 1'b1, 5, 8'h10);
    send_item(CMD_WRITE, 1'b0, 5, 8'h20);
    send_item(CMD_WRITE, 1'b1, 2, 8'h30);
    send_item(CMD_WRITE, 1'b0, 0, 8'h40);
    send_item(CMD_WRITE, 1'b1, 8191, 8'h50);
    send_item(CMD_WRITE, 1'b0, 0, 8'h60);
    send_item(CMD_WRITE, 1'b0, 0, 8'h70);
    send_item(CMD_WRITE, 1'b1, LEN_W'(DEPTH), 8'h80);
  endtask

  // Read rules: bad lengths, too few bytes held, and good short reads.
  task automatic test_read_rules();
    send_item(CMD_READ, 1'b0, 0, 8'h00);
    send_item(CMD_READ, 1'b1, LEN_W'(MAX_READ + 1), 8'hFF);
    send_item(CMD_READ, 1'b0, 8191, 8'h00);
    send_item(CMD_READ, 1'b0, LEN_W'(MAX_READ), 8'h00);
    send_item(CMD_READ, 1'b0, 1, 8'h00);
    send_item(CMD_READ, 1'b1, 3, 8'h00);
  endtask

  // Clear empties the queue; command three is refused.
  task automatic test_clear_and_unused();
    send_item(CMD_CLEAR, 1'b1, 8191, 8'hFF);
    send_item(CMD_READ, 1'b0, 1, 8'h00);
    send_item(CMD_UNUSED, 1'b1, 8191, 8'hFF);
    send_item(CMD_WRITE, 1'b1, 1, 8'hC3);
    send_item(CMD_READ, 1'b0, 1, 8'h00);
  endtask

  // A burst that exactly fits the free space is taken and one byte longer is
  // refused; a read run of the longest length is served and then refused.
  task automatic test_space_and_long_read();
    send_item(CMD_CLEAR, 1'b0, 0, 8'h00);
    send_burst(8, 8);
    send_item(CMD_WRITE, 1'b1, LEN_W'(DEPTH - held + 1), 8'hE1);
    send_item(CMD_WRITE, 1'b0, 0, 8'hE2);
    send_burst(DEPTH - held, 6);
    send_burst(MAX_READ, MAX_READ);
    send_item(CMD_READ, 1'b0, LEN_W'(MAX_READ), 8'h00);
    send_item(CMD_READ, 1'b0, LEN_W'(MAX_READ), 8'h00);
    send_item(CMD_READ, 1'b0, 9, 8'h00);
    send_item(CMD_READ, 1'b0, 1, 8'h00);
  endtask

  // Mostly well-formed bursts and reads, with broken bursts and noise mixed in.
  task automatic test_random_traffic();
    int first;
    int k;
    int kind;
    int n;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      k = items_sent - first;
      idle_pct  = (k >= 60 && k < 140) ? 0 : IDLE_PCT;
      stall_pct = idle_pct;
      kind = $urandom_range(99);
      if (kind < 50) begin
        n = $urandom_range(1, 12);
        send_burst(n, n);
      end else if (kind < 80) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_READ) : $urandom_range(1, 8);
        send_item(CMD_READ, 1'($urandom_range(1)), LEN_W'(n),
                  BYTE_W'($urandom_range(255)));
      end else if (kind < 83) begin
        send_item(CMD_CLEAR, 1'($urandom_range(1)), LEN_W'($urandom_range(8191)),
                  BYTE_W'($urandom_range(255)));
      end else if (kind < 90) begin
        n = $urandom_range(2, 12);
        send_burst(n, $urandom_range(1, n - 1));
      end else begin
        send_item(CMD_W'($urandom_range(3)), 1'($urandom_range(1)),
                  LEN_W'($urandom_range(8191)), BYTE_W'($urandom_range(255)));
      end
    end
    idle_pct  = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  initial begin
    rd_pos = 0;
    wr_pos = 0;
    held = 0;
    burst_left = 0;
    burst_dropped = 0;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_cmd             <= CMD_WRITE;
    in_burst_start     <= 1'b0;
    in_transfer_length <= '0;
    in_data_byte       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_write_rules();
    test_read_rules();
    test_clear_and_unused();
    wait_until_drained();
    test_space_and_long_read();
    wait_until_drained();
    test_random_traffic();
    wait_until_drained();

    if (pending_results.size() != 0)
      report_mismatch("expected results left over", pending_results.size(), 0);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
src/brq_pkg.sv
src/brq_store.sv
src/brq_ctrl.sv
src/brq_outbuf.sv
src/byte_ring_queue_all_or_nothing_core.sv
src/brq_checker.sv
dv/tb_byte_ring_queue_all_or_nothing_core.sv
